// ----- sv/legendre_series_forward_recurrence_assert.svh -----
// assertion macros for the legendre series evaluator checker
// no dependencies; included by the checker file
`ifndef LEGENDRE_SERIES_FORWARD_RECURRENCE_ASSERT_SVH
`define LEGENDRE_SERIES_FORWARD_RECURRENCE_ASSERT_SVH

// consequent checked in the same cycle as the antecedent
`define LGSER_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked in the cycle after the antecedent
`define LGSER_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/lgser_pkg.sv -----
// shared widths, types and constants of the legendre series evaluator
// no dependencies
`timescale 1ns / 1ps

package lgser_pkg;

  localparam int unsigned XW    = 32;       // point, Q1.30
  localparam int unsigned CW    = 32;       // coefficient, Q15.16
  localparam int unsigned PW    = 34;       // legendre values, Q3.30
  localparam int unsigned TW    = 36;       // x * p_k, Q5.30
  localparam int unsigned SumW  = 42;       // accumulator, enough for 64 full-scale terms
  localparam int unsigned ValW  = 48;       // result, Q31.16
  localparam int unsigned CntW  = 7;
  localparam int unsigned K1W   = 33;       // (2k+1) / (k+1) in Q1.32
  localparam int unsigned K2W   = 32;       // k / (k+1) in Q0.32
  localparam int unsigned AW    = TW;
  localparam int unsigned BW    = 34;
  localparam int unsigned ProdW = AW + BW;
  localparam int unsigned FracP = 30;
  localparam int unsigned FracR = 32;

  typedef logic signed [XW-1:0]    x_t;
  typedef logic signed [CW-1:0]    coef_t;
  typedef logic signed [PW-1:0]    poly_t;
  typedef logic signed [TW-1:0]    tval_t;
  typedef logic signed [SumW-1:0]  sum_t;
  typedef logic signed [ValW-1:0]  val_t;
  typedef logic        [CntW-1:0]  cnt_t;
  typedef logic        [K1W-1:0]   k1_t;
  typedef logic        [K2W-1:0]   k2_t;
  typedef logic signed [AW-1:0]    mul_a_t;
  typedef logic signed [BW-1:0]    mul_b_t;
  typedef logic signed [ProdW-1:0] prod_t;

  localparam poly_t PolyOne  = poly_t'(1) <<< FracP;
  localparam prod_t RndP     = prod_t'(1) <<< (FracP - 1);
  localparam prod_t RndR     = prod_t'(1) <<< (FracR - 1);
  localparam prod_t PolyHi   = (prod_t'(1) <<< (PW - 1)) - prod_t'(1);
  localparam prod_t PolyLo   = -(prod_t'(1) <<< (PW - 1));
  localparam poly_t PolyMaxV = poly_t'(PolyHi);
  localparam poly_t PolyMinV = poly_t'(PolyLo);

endpackage

// ----- sv/lgser_if.sv -----
// coefficient and result channels of the legendre series evaluator
// depends on lgser_pkg
`timescale 1ns / 1ps

interface lgser_in_if;
  logic              valid;
  logic              ready;
  lgser_pkg::x_t     point_x;
  lgser_pkg::coef_t  coefficient;
  logic              last_coeff;

  modport source (output valid, output point_x, output coefficient, output last_coeff,
                  input ready);
  modport sink   (input valid, input point_x, input coefficient, input last_coeff,
                  output ready);
endinterface

interface lgser_out_if;
  logic              valid;
  logic              ready;
  lgser_pkg::val_t   series_value;
  lgser_pkg::cnt_t   term_count;
  logic              overflow;

  modport source (output valid, output series_value, output term_count, output overflow,
                  input ready);
  modport sink   (input valid, input series_value, input term_count, input overflow,
                  output ready);
endinterface

// ----- sv/lgser_mult.sv -----
// shared signed multiplier of the legendre series evaluator
// depends on lgser_pkg
`timescale 1ns / 1ps

module lgser_mult (
  input  lgser_pkg::mul_a_t a_i,
  input  lgser_pkg::mul_b_t b_i,
  output lgser_pkg::prod_t  p_o
);

  // full-precision signed product, both operands sign extended
  assign p_o = lgser_pkg::prod_t'(a_i) * lgser_pkg::prod_t'(b_i);

endmodule

// ----- sv/legendre_series_forward_recurrence.sv -----
// legendre series evaluator, forward three-term recurrence, one shared 36x34 multiplier
// coefficient item: taken in S_IDLE, then 4 multiplier passes (sum term, x*p_k, two
//   recurrence products; only the sum term for a last item or one that fills the series),
//   no new item meanwhile; a last item's result is loaded in S_OUT once there is room
// async active-low reset clears the series state (p_k = 1.0) and the result register
`timescale 1ns / 1ps

module legendre_series_forward_recurrence #(
  parameter int unsigned MaxTerms = 64
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  lgser_in_if.sink         coeff_i,
  lgser_out_if.source      result_o
);

  localparam int unsigned IdxW = (MaxTerms > 1) ? $clog2(MaxTerms) : 1;
  localparam lgser_pkg::cnt_t MaxCnt = lgser_pkg::cnt_t'(MaxTerms);

  typedef enum logic [2:0] {
    S_IDLE,    // waiting for a coefficient
    S_SUM,     // sum += p_k * c
    S_TPT,     // t = x * p_k
    S_PRODA,   // d = t * (2k+1)/(k+1)
    S_PRODB,   // p_k+1 = d - p_k-1 * k/(k+1), rounded and saturated
    S_OUT      // load the result register
  } state_e;

  state_e             state_q;
  lgser_pkg::x_t      held_x_q;
  lgser_pkg::coef_t   coeff_q;
  logic               last_q;
  lgser_pkg::poly_t   prev_q;    // p_k, order of the coming coefficient
  lgser_pkg::poly_t   curr_q;    // p_k-1
  lgser_pkg::sum_t    sum_q;
  lgser_pkg::cnt_t    cnt_q;
  logic               ovf_q;
  lgser_pkg::tval_t   t_q;
  lgser_pkg::prod_t   dacc_q;
  logic               out_valid_q;
  lgser_pkg::val_t    out_value_q;
  lgser_pkg::cnt_t    out_count_q;
  logic               out_ovf_q;

  // ---------------------------------------------------------------------------
  // recurrence factor tables: r(k) = round(2^32 / (k+1)) folded into the two
  // small multipliers, so the product of d and r(k) splits into two exact
  // products that the shared multiplier can take
  // ---------------------------------------------------------------------------
  lgser_pkg::k1_t k1_tab [MaxTerms];
  lgser_pkg::k2_t k2_tab [MaxTerms];

  for (genvar g = 0; g < MaxTerms; g++) begin : g_rcp
    localparam longint unsigned Den = longint'(g) + 64'd1;
    localparam longint unsigned Rcp = ((64'd1 << 32) + Den / 64'd2) / Den;
    assign k1_tab[g] = lgser_pkg::k1_t'((64'd2 * Den - 64'd1) * Rcp);
    assign k2_tab[g] = lgser_pkg::k2_t'((Den - 64'd1) * Rcp);
  end

  // order k of the recurrence step, the count is already advanced there
  lgser_pkg::cnt_t cnt_inc;
  lgser_pkg::cnt_t k_cnt;
  logic [IdxW-1:0] k_idx;

  assign cnt_inc = cnt_q + lgser_pkg::cnt_t'(1);
  assign k_cnt   = cnt_q - lgser_pkg::cnt_t'(1);
  assign k_idx   = k_cnt[IdxW-1:0];

  // ---------------------------------------------------------------------------
  // operand selection for the shared multiplier
  // ---------------------------------------------------------------------------
  lgser_pkg::mul_a_t mul_a;
  lgser_pkg::mul_b_t mul_b;
  lgser_pkg::prod_t  prod;

  always_comb begin
    unique case (state_q)
      S_SUM: begin
        mul_a = lgser_pkg::mul_a_t'(prev_q);
        mul_b = lgser_pkg::mul_b_t'(coeff_q);
      end
      S_TPT: begin
        mul_a = lgser_pkg::mul_a_t'(prev_q);
        mul_b = lgser_pkg::mul_b_t'(held_x_q);
      end
      S_PRODA: begin
        mul_a = lgser_pkg::mul_a_t'(t_q);
        mul_b = lgser_pkg::mul_b_t'({1'b0, k1_tab[k_idx]});
      end
      S_PRODB: begin
        mul_a = lgser_pkg::mul_a_t'(curr_q);
        mul_b = lgser_pkg::mul_b_t'({2'b00, k2_tab[k_idx]});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  lgser_mult u_mult (
    .a_i (mul_a),
    .b_i (mul_b),
    .p_o (prod)
  );

  // round half up, dropping 30 fraction bits: the sum term lands in Q.16, x * p_k in Q.30
  lgser_pkg::prod_t rnd_p;
  assign rnd_p = (prod + lgser_pkg::RndP) >>> lgser_pkg::FracP;

  // next legendre value: round half up of the Q.62 difference to Q.30, then saturate to 34 bits
  lgser_pkg::prod_t nxt_full;
  logic             nxt_hi;
  logic             nxt_lo;
  lgser_pkg::poly_t nxt_sat;

  assign nxt_full = (dacc_q - prod + lgser_pkg::RndR) >>> lgser_pkg::FracR;
  assign nxt_hi   = nxt_full > lgser_pkg::PolyHi;
  assign nxt_lo   = nxt_full < lgser_pkg::PolyLo;
  assign nxt_sat  = nxt_hi ? lgser_pkg::PolyMaxV :
                    nxt_lo ? lgser_pkg::PolyMinV : lgser_pkg::poly_t'(nxt_full);

  // ---------------------------------------------------------------------------
  // sequencer, series state and result register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      held_x_q    <= '0;
      coeff_q     <= '0;
      last_q      <= 1'b0;
      prev_q      <= lgser_pkg::PolyOne;
      curr_q      <= '0;
      sum_q       <= '0;
      cnt_q       <= '0;
      ovf_q       <= 1'b0;
      t_q         <= '0;
      dacc_q      <= '0;
      out_valid_q <= 1'b0;
      out_value_q <= '0;
      out_count_q <= '0;
      out_ovf_q   <= 1'b0;
    end else begin
      // result leaves on its transfer, unless a new one takes its place
      if (out_valid_q && result_o.ready && (state_q != S_OUT)) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (coeff_i.valid) begin
            coeff_q <= coeff_i.coefficient;
            last_q  <= coeff_i.last_coeff;
            // point is taken only at the start of a series
            if (cnt_q == '0) begin
              held_x_q <= coeff_i.point_x;
            end
            if (cnt_q < MaxCnt) begin
              state_q <= S_SUM;
            end else begin
              // series already full: the coefficient is dropped and flagged
              ovf_q   <= 1'b1;
              state_q <= coeff_i.last_coeff ? S_OUT : S_IDLE;
            end
          end
        end
        S_SUM: begin
          sum_q <= sum_q + lgser_pkg::sum_t'(rnd_p);
          cnt_q <= cnt_inc;
          if (last_q) begin
            state_q <= S_OUT;
          end else if (cnt_inc < MaxCnt) begin
            state_q <= S_TPT;
          end else begin
            state_q <= S_IDLE;
          end
        end
        S_TPT: begin
          t_q     <= lgser_pkg::tval_t'(rnd_p);
          state_q <= S_PRODA;
        end
        S_PRODA: begin
          dacc_q  <= prod;
          state_q <= S_PRODB;
        end
        S_PRODB: begin
          curr_q  <= prev_q;
          prev_q  <= nxt_sat;
          if (nxt_hi || nxt_lo) begin
            ovf_q <= 1'b1;
          end
          state_q <= S_IDLE;
        end
        S_OUT: begin
          // wait for room in the result register
          if (!out_valid_q || result_o.ready) begin
            out_valid_q <= 1'b1;
            // accumulator cannot reach the 48-bit limit, so a sign extension is exact
            out_value_q <= lgser_pkg::val_t'(sum_q);
            out_count_q <= cnt_q;
            out_ovf_q   <= ovf_q;
            // back to the start of a series
            held_x_q    <= '0;
            prev_q      <= lgser_pkg::PolyOne;
            curr_q      <= '0;
            sum_q       <= '0;
            cnt_q       <= '0;
            ovf_q       <= 1'b0;
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign coeff_i.ready         = (state_q == S_IDLE);
  assign result_o.valid        = out_valid_q;
  assign result_o.series_value = out_value_q;
  assign result_o.term_count   = out_count_q;
  assign result_o.overflow     = out_ovf_q;

endmodule

// ----- sv/lgser_chk.sv -----
// port-level checker of the legendre series evaluator, bound to the top level
// depends on lgser_pkg and legendre_series_forward_recurrence_assert.svh
`timescale 1ns / 1ps
`include "legendre_series_forward_recurrence_assert.svh"

module lgser_chk #(
  parameter int unsigned MaxTerms = 64
) (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            in_valid_i,
  input logic            in_ready_i,
  input logic            in_last_i,
  input logic            out_valid_i,
  input logic            out_ready_i,
  input lgser_pkg::cnt_t term_count_i
);

  localparam lgser_pkg::cnt_t MaxCnt = lgser_pkg::cnt_t'(MaxTerms);

  // a held result stays until its transfer
  `LGSER_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i, "result dropped while stalled")

  // a closing coefficient blocks the input while its result is formed
  `LGSER_ASSERT_NEXT(a_last_busy, clk_i, rst_ni, in_valid_i && in_ready_i && in_last_i, !in_ready_i, "input open right after last coefficient")

  // a new result only appears after the input was closed
  `LGSER_ASSERT_NOW(a_out_after_busy, clk_i, rst_ni, $rose(out_valid_i), !$past(in_ready_i), "result without a busy cycle")

  // every result counts at least one and at most the configured number of terms
  `LGSER_ASSERT_NOW(a_count_range, clk_i, rst_ni, out_valid_i, (term_count_i != '0) && (term_count_i <= MaxCnt), "term count out of range")

endmodule

bind legendre_series_forward_recurrence lgser_chk #(
  .MaxTerms (MaxTerms)
) u_lgser_chk (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (coeff_i.valid),
  .in_ready_i   (coeff_i.ready),
  .in_last_i    (coeff_i.last_coeff),
  .out_valid_i  (result_o.valid),
  .out_ready_i  (result_o.ready),
  .term_count_i (result_o.term_count)
);

// ----- sim/tb_legendre_series_forward_recurrence.sv -----
// self-checking bench for the legendre series evaluator: directed and random coefficient series
// predicts every sum in fixed point and checks each result transfer; needs lgser_pkg, lgser_if
`timescale 1ns / 1ps

module tb_legendre_series_forward_recurrence;

  // terms the block holds before it flags overflow
  localparam int unsigned TermLimit  = 64;
  localparam int unsigned ItemTarget = 1600;
  // idle cycles (no transfer on either side) before the run is called hung
  localparam int unsigned IdleLimit  = 4000;
  // cycles allowed for the last result to settle at the end
  localparam int unsigned TailCycles = 20;

  // directed corner values, Q1.30 points and Q15.16 coefficients
  localparam lgser_pkg::x_t    XZero     = 32'sh0000_0000;
  localparam lgser_pkg::x_t    XOne      = 32'sh4000_0000;
  localparam lgser_pkg::x_t    XMinusOne = -32'sh4000_0000;
  localparam lgser_pkg::x_t    XHalf     = 32'sh2000_0000;
  localparam lgser_pkg::x_t    XMax      = 32'sh7fff_ffff;
  localparam lgser_pkg::x_t    XMin      = -32'sh8000_0000;
  localparam lgser_pkg::coef_t CZero     = 32'sh0000_0000;
  localparam lgser_pkg::coef_t COne      = 32'sh0001_0000;
  localparam lgser_pkg::coef_t CMax      = 32'sh7fff_ffff;
  localparam lgser_pkg::coef_t CMin      = -32'sh8000_0000;
  localparam lgser_pkg::coef_t CLsb      = 32'sh0000_0001;

  typedef struct {
    lgser_pkg::val_t value;
    lgser_pkg::cnt_t count;
    logic            ovf;
  } sum_result_t;

  logic clk_i;
  logic rst_ni;

  lgser_in_if  coeff_ch ();
  lgser_out_if result_ch ();

  legendre_series_forward_recurrence dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .coeff_i  (coeff_ch),
    .result_o (result_ch)
  );

  // expected sums, oldest first
  sum_result_t pending_sums[$];

  // shadow of the series state: latched point, p_k, p_{k-1}, accumulator
  longint      held_x;
  longint      p_now;
  longint      p_back;
  longint      acc;
  int unsigned terms;
  bit          ovf_flag;

  int unsigned err_count;
  int unsigned sent_items;
  int unsigned series_sent;
  int unsigned results_seen;
  int unsigned coeff_gap;
  // while set, neither side inserts gaps or stalls
  bit          no_gaps;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // fixed-point helpers of the predictor
  // ---------------------------------------------------------------------------

  // a*b / 2^s rounded half up; 128 bits leave ample headroom
  function automatic longint round_mul(longint a, longint b, int unsigned s);
    logic signed [127:0] p;
    logic signed [127:0] half;
    p    = a;
    p    = p * b;
    half = 1;
    half = half <<< (s - 1);
    p    = (p + half) >>> s;
    return longint'(p[63:0]);
  endfunction

  // clamp to a signed field of the given width, flag when clipped
  function automatic longint clamp_bits(longint v, int unsigned bits, output bit hit);
    longint lim;
    lim = longint'(1) <<< (bits - 1);
    hit = 1'b0;
    if (v > lim - 1) begin
      hit = 1'b1;
      return lim - 1;
    end
    if (v < -lim) begin
      hit = 1'b1;
      return -lim;
    end
    return v;
  endfunction

  // 1/(k+1) in Q1.32, rounded
  function automatic longint recip_q32(int unsigned k);
    longint unsigned d;
    d = longint'(k & 127) + 1;
    return longint'(((longint'(1) << 32) + d / 2) / d);
  endfunction

  function automatic void clear_series();
    held_x   = 0;
    p_now    = longint'(1) <<< 30;
    p_back   = 0;
    acc      = 0;
    terms    = 0;
    ovf_flag = 1'b0;
  endfunction

  // advance the shadow series by one accepted coefficient
  function automatic void predict_coeff(lgser_pkg::x_t x, lgser_pkg::coef_t c, logic last);
    longint      t;
    longint      d;
    longint      nxt;
    int unsigned k;
    bit          hit;
    bit          sat;
    sum_result_t r;
    // point only counts on the first coefficient of a series
    if (terms == 0) held_x = longint'(x);
    if (terms < TermLimit) begin
      k     = terms;
      acc   = acc + round_mul(p_now, longint'(c), 30);
      terms = terms + 1;
      if (!last && terms < TermLimit) begin
        // p_{k+1} = ((2k+1) x p_k - k p_{k-1}) / (k+1)
        t   = round_mul(p_now, held_x, 30);
        d   = longint'(2 * k + 1) * t - longint'(k) * p_back;
        nxt = clamp_bits(round_mul(d, recip_q32(k), 32), lgser_pkg::PW, hit);
        if (hit) ovf_flag = 1'b1;
        p_back = p_now;
        p_now  = nxt;
      end
    end else begin
      // past the term limit the coefficient is dropped
      ovf_flag = 1'b1;
    end
    if (last) begin
      r.value = lgser_pkg::val_t'(clamp_bits(acc, lgser_pkg::ValW, sat));
      r.count = lgser_pkg::cnt_t'(terms);
      r.ovf   = ovf_flag | sat;
      pending_sums.push_back(r);
      clear_series();
    end
  endfunction

  // ---------------------------------------------------------------------------
  // idling and the sender side
  // ---------------------------------------------------------------------------

  // mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (no_gaps) return 0;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(10, 4);
    return $urandom_range(40, 20);
  endfunction

  // one coefficient transfer; valid stays up when the next item follows at once
  task automatic send_coeff(lgser_pkg::x_t x, lgser_pkg::coef_t c, logic last);
    repeat (coeff_gap) @(posedge clk_i);
    coeff_ch.valid       <= 1'b1;
    coeff_ch.point_x     <= x;
    coeff_ch.coefficient <= c;
    coeff_ch.last_coeff  <= last;
    @(posedge clk_i);
    while (!coeff_ch.ready) @(posedge clk_i);
    predict_coeff(x, c, last);
    sent_items++;
    if (last) series_sent++;
    coeff_gap = pick_gap();
    if (coeff_gap != 0) coeff_ch.valid <= 1'b0;
  endtask

  // send a whole series; later points are random, the block must ignore them
  task automatic send_series(lgser_pkg::x_t x, int unsigned len, int unsigned coef_mode);
    lgser_pkg::coef_t c;
    lgser_pkg::x_t    xi;
    for (int unsigned i = 0; i < len; i++) begin
      case (coef_mode)
        0: c = lgser_pkg::coef_t'($urandom);
        1: c = lgser_pkg::coef_t'(longint'($urandom_range(32'h0020_0000, 0))
                                  - 64'sh0010_0000);
        default: begin
          case ($urandom_range(3))
            0: c = CMax;
            1: c = CMin;
            2: c = COne;
            default: c = CZero;
          endcase
        end
      endcase
      xi = (i == 0) ? x : lgser_pkg::x_t'($urandom);
      send_coeff(xi, c, i == len - 1);
    end
  endtask

  function automatic lgser_pkg::x_t pick_point();
    // most points inside -1..1, the rest anywhere
    if ($urandom_range(99) < 80)
      return lgser_pkg::x_t'(longint'($urandom_range(32'h8000_0000, 0)) - 64'sh4000_0000);
    return lgser_pkg::x_t'($urandom);
  endfunction

  // ---------------------------------------------------------------------------
  // checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(string field, longint got, longint want);
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, field, got, want);
    err_count++;
  endtask

  // result side: random ready stalls, every result transfer checked
  initial begin : result_checker
    sum_result_t want;
    int unsigned stall_left;
    stall_left = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (result_ch.valid && result_ch.ready) begin
        results_seen++;
        if (pending_sums.size() == 0) begin
          report_mismatch("result with no expectation", longint'(result_ch.series_value), 0);
        end else begin
          want = pending_sums.pop_front();
          if (result_ch.series_value !== want.value)
            report_mismatch("series_value", longint'(result_ch.series_value),
                            longint'(want.value));
          if (result_ch.term_count !== want.count)
            report_mismatch("term_count", longint'(result_ch.term_count), longint'(want.count));
          if (result_ch.overflow !== want.ovf)
            report_mismatch("overflow", longint'(result_ch.overflow), longint'(want.ovf));
        end
      end
      if (stall_left == 0) stall_left = pick_gap();
      if (stall_left != 0) begin
        result_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        result_ch.ready <= 1'b1;
      end
    end
  end

  // hang detector: cycles in a row with no transfer on either channel
  initial begin : watchdog
    int unsigned idle;
    idle = 0;
    while (idle < IdleLimit) begin
      @(posedge clk_i);
      if ((coeff_ch.valid && coeff_ch.ready) || (result_ch.valid && result_ch.ready))
        idle = 0;
      else
        idle++;
    end
    $display("[%0t] no transfer for %0d cycles", $realtime, IdleLimit);
    $display("TEST FAILED");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // one-term series: the sum is c * 1.0 whatever the point
  task automatic test_single_terms();
    send_coeff(XZero, CMax, 1'b1);
    send_coeff(XMin, CMin, 1'b1);
    send_coeff(XMax, CZero, 1'b1);
    send_coeff(XMinusOne, CLsb, 1'b1);
  endtask

  // at x = +-1 every p_k is +-1, so the recurrence is exact
  task automatic test_unit_points();
    send_coeff(XOne, COne, 1'b0);
    send_coeff(XZero, CMax, 1'b0);
    send_coeff(XMax, CMin, 1'b0);
    send_coeff(XMin, COne, 1'b1);
    send_coeff(XMinusOne, COne, 1'b0);
    send_coeff(XOne, CMax, 1'b0);
    send_coeff(XZero, CMax, 1'b1);
  endtask

  // points near +-2 drive p_k into saturation of the Q3.30 range
  task automatic test_point_outside_range();
    for (int i = 0; i < 6; i++) send_coeff(XMax, COne, i == 5);
    for (int i = 0; i < 5; i++) send_coeff(XMin, CMax, i == 4);
  endtask

  // point on later coefficients differs wildly and must not be used
  task automatic test_point_ignored();
    send_coeff(XHalf, COne, 1'b0);
    send_coeff(XMin, COne, 1'b0);
    send_coeff(XMax, COne, 1'b1);
  endtask

  // exactly the limit, one past it, several past it, and one short of it
  task automatic test_term_limit();
    send_series(pick_point(), TermLimit, 0);
    send_series(pick_point(), TermLimit + 1, 1);
    send_series(XMax, TermLimit + 6, 2);
    send_series(pick_point(), TermLimit - 1, 0);
  endtask

  // random series, mostly short, some around the term limit
  task automatic test_random_series();
    int unsigned r;
    int unsigned len;
    int unsigned mode;
    while (sent_items < ItemTarget) begin
      no_gaps = ($urandom_range(99) < 15);
      r = $urandom_range(99);
      if (r < 75)      len = $urandom_range(10, 1);
      else if (r < 90) len = $urandom_range(40, 11);
      else             len = $urandom_range(TermLimit + 6, TermLimit - 4);
      r = $urandom_range(99);
      mode = (r < 60) ? 0 : (r < 90) ? 1 : 2;
      send_series(pick_point(), len, mode);
    end
    no_gaps = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------

  initial begin : main_seq
    err_count    = 0;
    sent_items   = 0;
    series_sent  = 0;
    results_seen = 0;
    coeff_gap    = 0;
    no_gaps      = 1'b0;
    clear_series();

    rst_ni               <= 1'b0;
    coeff_ch.valid       <= 1'b0;
    coeff_ch.point_x     <= XZero;
    coeff_ch.coefficient <= CZero;
    coeff_ch.last_coeff  <= 1'b0;
    result_ch.ready      <= 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_single_terms();
    test_unit_points();
    test_point_outside_range();
    test_point_ignored();
    test_term_limit();
    test_random_series();

    // stop sending, wait for all sums to come back, then let the block settle
    if (coeff_gap == 0) coeff_ch.valid <= 1'b0;
    while (pending_sums.size() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);

    $display("covered %0d coefficients in %0d series, %0d results checked, %0d mismatches",
             sent_items, series_sent, results_seen, err_count);
    if (err_count == 0 && pending_sums.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+sv
sv/lgser_pkg.sv
sv/lgser_if.sv
sv/lgser_mult.sv
sv/legendre_series_forward_recurrence.sv
sv/lgser_chk.sv
sim/tb_legendre_series_forward_recurrence.sv
